// ===== rtl/utf8_to_utf16_strict_decoder_macros.svh =====
// Assertion helpers used by the checker file u8u16_checker.sv.
`ifndef UTF8_TO_UTF16_STRICT_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_STRICT_DECODER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define U8U16_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define U8U16_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/u8u16_pkg.sv =====
`timescale 1ns / 1ps
package u8u16_pkg;

	// Decoder phase
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ONE  = 2'd1,
		PH_TWO  = 2'd2,
		PH_DROP = 2'd3
	} phase_t;

	// Result kind codes
	localparam logic [1:0] KIND_UNIT   = 2'd0;
	localparam logic [1:0] KIND_TERM   = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	localparam logic [15:0] CAP_RESET = 16'hFFFF;

	// One step's result word
	typedef struct packed {
		logic        valid;
		logic [15:0] code_unit;
		logic [1:0]  kind;
		logic [15:0] word_total;
		logic        last;
	} step_res_t;

endpackage

// ===== rtl/u8u16_core.sv =====
`timescale 1ns / 1ps
module u8u16_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step_en,
	input  logic [7:0]             in_byte,
	input  logic [15:0]            word_capacity,
	output u8u16_pkg::step_res_t   res
);

	u8u16_pkg::phase_t phase_q, phase_n;
	logic [9:0]  pp_q, pp_n;
	logic        n3_q, n3_n;
	logic [15:0] wd_q, wd_n;

	logic        cont;
	logic [5:0]  low6;
	logic [15:0] cp3;
	logic [16:0] wd_p1;
	logic [16:0] cap17;
	logic        rej, unit, term;
	logic [15:0] unit_cp;

	assign cont  = (in_byte[7:6] == 2'b10);
	assign low6  = in_byte[5:0];
	assign cp3   = {pp_q, low6};
	assign wd_p1 = {1'b0, wd_q} + 17'd1;
	assign cap17 = {1'b0, word_capacity};

	// Decode the byte against the running state
	always_comb begin
		phase_n = phase_q;
		pp_n    = pp_q;
		n3_n    = n3_q;
		wd_n    = wd_q;
		rej     = 1'b0;
		unit    = 1'b0;
		term    = 1'b0;
		unit_cp = 16'd0;
		unique case (phase_q)
			u8u16_pkg::PH_DROP: begin
				if (in_byte == 8'd0) begin
					phase_n = u8u16_pkg::PH_IDLE;
					wd_n    = 16'd0;
				end
			end
			u8u16_pkg::PH_ONE: begin
				if (!cont) begin
					rej = 1'b1;
				end else if (n3_q) begin
					// overlong form or surrogate
					if (cp3[15:11] == 5'd0 || cp3[15:11] == 5'b11011) begin
						rej = 1'b1;
					end else begin
						unit    = 1'b1;
						unit_cp = cp3;
					end
				end else begin
					unit    = 1'b1;
					unit_cp = {5'd0, pp_q[4:0], low6};
				end
			end
			u8u16_pkg::PH_TWO: begin
				if (!cont) begin
					rej = 1'b1;
				end else begin
					pp_n    = {pp_q[3:0], low6};
					phase_n = u8u16_pkg::PH_ONE;
				end
			end
			u8u16_pkg::PH_IDLE: begin
				priority if (in_byte == 8'd0) begin
					if (wd_p1 > cap17) begin
						rej = 1'b1;
					end else begin
						term = 1'b1;
						wd_n = 16'd0;
					end
				end else if (!in_byte[7]) begin
					unit    = 1'b1;
					unit_cp = {8'd0, in_byte};
				end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
					pp_n    = {5'd0, in_byte[4:0]};
					n3_n    = 1'b0;
					phase_n = u8u16_pkg::PH_ONE;
				end else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
					pp_n    = {6'd0, in_byte[3:0]};
					n3_n    = 1'b1;
					phase_n = u8u16_pkg::PH_TWO;
				end else begin
					rej = 1'b1;
				end
			end
		endcase

		// Capacity check on a code unit
		if (unit && wd_p1 >= cap17) begin
			rej  = 1'b1;
			unit = 1'b0;
		end

		if (rej) begin
			phase_n = (in_byte == 8'd0) ? u8u16_pkg::PH_IDLE : u8u16_pkg::PH_DROP;
			pp_n    = 10'd0;
			n3_n    = 1'b0;
			wd_n    = 16'd0;
		end else if (unit) begin
			phase_n = u8u16_pkg::PH_IDLE;
			pp_n    = 10'd0;
			n3_n    = 1'b0;
			wd_n    = wd_p1[15:0];
		end
	end

	// Build the result word
	always_comb begin
		res            = '0;
		res.valid      = rej | unit | term;
		res.code_unit  = unit ? unit_cp : 16'd0;
		res.word_total = term ? wd_p1[15:0] : 16'd0;
		res.last       = rej | term;
		if (rej) begin
			res.kind = u8u16_pkg::KIND_REJECT;
		end else if (term) begin
			res.kind = u8u16_pkg::KIND_TERM;
		end else begin
			res.kind = u8u16_pkg::KIND_UNIT;
		end
	end

	// Advance the state when a word is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= u8u16_pkg::PH_IDLE;
			pp_q    <= 10'd0;
			n3_q    <= 1'b0;
			wd_q    <= 16'd0;
		end else if (step_en) begin
			phase_q <= phase_n;
			pp_q    <= pp_n;
			n3_q    <= n3_n;
			wd_q    <= wd_n;
		end
	end

endmodule

// ===== rtl/utf8_to_utf16_strict_decoder.sv =====
`timescale 1ns / 1ps
// Strict UTF-8 to UTF-16 (BMP) string decoder.
// Input channel: in_valid/in_ready with in_byte, one UTF-8 byte per word;
// a zero byte ends the string. Output channel: out_valid/out_ready with
// code_unit, kind, word_total and last. Each byte gives zero or one result:
// a code unit (kind 0), the terminator with its word count (kind 1, last),
// or a single reject for the string (kind 2, last), after which, unless
// the zero byte itself was rejected, bytes are dropped through the next zero byte without results.
// word_capacity is set through cfg_we/cfg_wdata; write it only while idle.
// An accepted byte is held in the input register, and its result then
// in the result register. Throughput: one byte per cycle while the
// receiver takes results, set by the single decode stage between the two registers.
// When the receiver stalls, the result register holds and the input
// register keeps taking one more byte; in_ready falls only once both are
// full. Reset empties both registers, returns the decoder to awaiting a
// lead byte with a zero word count, and sets the capacity to 65535.
module utf8_to_utf16_strict_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic [1:0]  kind,
	output logic [15:0] word_total,
	output logic        last
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic [15:0] cap_q;
	logic        out_valid_q;
	logic [15:0] code_unit_q;
	logic [1:0]  kind_q;
	logic [15:0] word_total_q;
	logic        last_q;

	u8u16_pkg::step_res_t res;

	// Consume the held byte when the result register can take its result
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Hold the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= u8u16_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	u8u16_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (advance),
		.in_byte       (byte_s1),
		.word_capacity (cap_q),
		.res           (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			code_unit_q  <= res.code_unit;
			kind_q       <= res.kind;
			word_total_q <= res.word_total;
			last_q       <= res.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign code_unit  = code_unit_q;
	assign kind       = kind_q;
	assign word_total = word_total_q;
	assign last       = last_q;

endmodule

// ===== rtl/u8u16_checker.sv =====
`timescale 1ns / 1ps
`include "utf8_to_utf16_strict_decoder_macros.svh"
module u8u16_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] code_unit,
	input logic [1:0]  kind,
	input logic [15:0] word_total,
	input logic        last
);

	// A stalled word stays offered unchanged
	`U8U16_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(code_unit) && $stable(kind) && $stable(word_total) && $stable(last), "stalled result changed")

	// Terminator and reject close the string and carry no unit
	`U8U16_ASSERT(a_end_fields, out_valid && (kind == u8u16_pkg::KIND_TERM || kind == u8u16_pkg::KIND_REJECT) |-> last && code_unit == 16'd0, "end result malformed")

	// Code units never close a string and carry no count
	`U8U16_ASSERT(a_unit_fields, out_valid && kind == u8u16_pkg::KIND_UNIT |-> !last && word_total == 16'd0, "code unit malformed")

	// An empty result register never blocks the input
	`U8U16_ASSERT(a_in_free, !out_valid |-> in_ready, "input blocked with no result waiting")

	// Nothing is offered while reset is held
	`U8U16_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !out_valid, "result offered in reset")

endmodule

bind utf8_to_utf16_strict_decoder u8u16_checker u_chk (.*);

// ===== tb/sv/utf16_word_checker.sv =====
`timescale 1ns / 1ps
module utf16_word_checker
	import u8u16_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] code_unit,
	input  logic [1:0]  kind,
	input  logic [15:0] word_total,
	input  logic        last,
	output int          fail_count,
	output int          words_pending
);

	typedef struct packed {
		logic [15:0] code_unit;
		logic [1:0]  kind;
		logic [15:0] word_total;
		logic        last;
	} utf16_word_t;

	utf16_word_t awaited_words [$];
	utf16_word_t want;

	// Shadow copy of the decoder state and its capacity register
	logic [15:0] capacity;
	phase_t      dec_phase;
	logic [9:0]  lead_bits;
	logic        three_byte;
	logic [15:0] units_so_far;
	int          failures = 0;

	function automatic void queue_word(input logic [15:0] unit, input logic [1:0] k,
			input logic [15:0] total, input logic fin);
		utf16_word_t w;
		w.code_unit  = unit;
		w.kind       = k;
		w.word_total = total;
		w.last       = fin;
		awaited_words.push_back(w);
	endfunction

	// Reject the string: a zero byte closes it at once, anything else starts dropping
	function automatic void reject_string(input logic [7:0] b);
		dec_phase    = (b == 8'h00) ? PH_IDLE : PH_DROP;
		lead_bits    = '0;
		three_byte   = 1'b0;
		units_so_far = '0;
		queue_word(16'h0000, KIND_REJECT, 16'h0000, 1'b1);
	endfunction

	// A unit needs room for itself and the terminator
	function automatic void emit_unit(input logic [15:0] point);
		if ({1'b0, units_so_far} + 17'd1 >= {1'b0, capacity}) begin
			reject_string(8'hFF);
		end else begin
			units_so_far = units_so_far + 16'd1;
			dec_phase    = PH_IDLE;
			lead_bits    = '0;
			three_byte   = 1'b0;
			queue_word(point, KIND_UNIT, 16'h0000, 1'b0);
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b);
		logic [5:0]  low6;
		logic        cont;
		logic [16:0] total;
		logic [15:0] point;
		low6 = b[5:0];
		cont = (b[7:6] == 2'b10);
		case (dec_phase)
		PH_DROP: begin
			if (b == 8'h00) begin
				dec_phase    = PH_IDLE;
				units_so_far = '0;
			end
		end
		PH_ONE: begin
			if (!cont) begin
				reject_string(b);
			end else if (three_byte) begin
				point = {lead_bits, low6};
				// overlong three-byte forms and surrogates fail on the last byte
				if (point < 16'h0800 || (point >= 16'hD800 && point <= 16'hDFFF))
					reject_string(b);
				else
					emit_unit(point);
			end else begin
				emit_unit({5'd0, lead_bits[4:0], low6});
			end
		end
		PH_TWO: begin
			if (!cont) begin
				reject_string(b);
			end else begin
				lead_bits = {lead_bits[3:0], low6};
				dec_phase = PH_ONE;
			end
		end
		default: begin
			if (b == 8'h00) begin
				total = {1'b0, units_so_far} + 17'd1;
				if (total > {1'b0, capacity}) begin
					reject_string(b);
				end else begin
					units_so_far = '0;
					queue_word(16'h0000, KIND_TERM, total[15:0], 1'b1);
				end
			end else if (b < 8'h80) begin
				emit_unit({8'd0, b});
			end else if (b >= 8'hC2 && b <= 8'hDF) begin
				lead_bits  = {5'd0, b[4:0]};
				three_byte = 1'b0;
				dec_phase  = PH_ONE;
			end else if (b >= 8'hE0 && b <= 8'hEF) begin
				lead_bits  = {6'd0, b[3:0]};
				three_byte = 1'b1;
				dec_phase  = PH_TWO;
			end else begin
				reject_string(b);
			end
		end
		endcase
	endfunction

	// Compare delivered words, then track config writes and accepted bytes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity     = CAP_RESET;
			dec_phase    = PH_IDLE;
			lead_bits    = '0;
			three_byte   = 1'b0;
			units_so_far = '0;
			awaited_words.delete();
			fail_count    <= failures;
			words_pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_words.size() == 0) begin
					$error("unexpected word: code_unit %h kind %0d word_total %0d last %0b",
						code_unit, kind, word_total, last);
					failures++;
				end else begin
					want = awaited_words.pop_front();
					if (code_unit !== want.code_unit) begin
						$error("code_unit mismatch: expected %h, got %h", want.code_unit, code_unit);
						failures++;
					end
					if (kind !== want.kind) begin
						$error("kind mismatch: expected %0d, got %0d", want.kind, kind);
						failures++;
					end
					if (word_total !== want.word_total) begin
						$error("word_total mismatch: expected %0d, got %0d",
							want.word_total, word_total);
						failures++;
					end
					if (last !== want.last) begin
						$error("last mismatch: expected %0b, got %0b", want.last, last);
						failures++;
					end
				end
			end
			if (cfg_we)
				capacity = cfg_wdata;
			if (in_valid && in_ready)
				decode_byte(in_byte);
			fail_count    <= failures;
			words_pending <= awaited_words.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import u8u16_pkg::*;

	localparam int LONG_HOLD   = 80;
	localparam int PHASE_BYTES = 185;
	localparam int PHASES      = 6;

	logic        clk;
	logic        arst_n;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid  = 1'b0;
	logic [7:0]  in_byte   = '0;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic [15:0] code_unit;
	logic [1:0]  kind;
	logic [15:0] word_total;
	logic        last;
	int          fail_count;
	int          words_pending;

	bit          idle_on;
	bit          long_hold_req;
	bit          long_hold_done;
	int          sent_in_phase;
	bit [7:0]    text [$];

	// Extremes of each form, then one string per rejection cause other than capacity
	bit [7:0] directed_text [$] = '{
		8'h01, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF, 8'h00,
		8'hE0, 8'hA0, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'h00,
		8'h80, 8'h00,
		8'hC1, 8'h00,
		8'hF0, 8'h00,
		8'hC2, 8'h00,
		8'hE0, 8'h9F, 8'hBF, 8'h00,
		8'hED, 8'hA0, 8'h80, 8'h00
	};

	utf8_to_utf16_strict_decoder uut (.*);

	utf16_word_checker words_chk (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400_000;
		$display("simulation failed");
		$finish;
	end

	// Receiver: random stall bursts, one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req && !long_hold_done) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_done = 1'b1;
				out_ready <= 1'b1;
			end else if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 4);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one byte, with an occasional gap first, and hold it until taken
	task automatic send_byte(input bit [7:0] b);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (!in_ready);
		sent_in_phase++;
	endtask

	task automatic send_text();
		foreach (text[i])
			send_byte(text[i]);
		text.delete();
	endtask

	// Let every expected word arrive, then allow for bytes still in the pipe
	task automatic drain();
		int guard;
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		for (guard = 0; guard < 4000 && words_pending != 0; guard++)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [15:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Append one well-formed BMP code point with random content
	function automatic void add_point();
		logic [15:0] cp;
		case ($urandom_range(0, 2))
		0: begin
			text.push_back(8'($urandom_range(1, 127)));
		end
		1: begin
			cp = 16'($urandom_range(16'h0080, 16'h07FF));
			text.push_back({3'b110, cp[10:6]});
			text.push_back({2'b10, cp[5:0]});
		end
		default: begin
			do cp = 16'($urandom_range(16'h0800, 16'hFFFF));
			while (cp >= 16'hD800 && cp <= 16'hDFFF);
			text.push_back({4'b1110, cp[15:12]});
			text.push_back({2'b10, cp[11:6]});
			text.push_back({2'b10, cp[5:0]});
		end
		endcase
	endfunction

	// Mostly clean strings; some broken by one fault, a few pure noise
	function automatic void build_text();
		int          shape;
		logic [7:0]  stop;
		shape = $urandom_range(0, 9);
		repeat ($urandom_range(0, (shape < 6) ? 8 : 3)) add_point();
		if (shape >= 6 && shape < 9) begin
			case ($urandom_range(0, 5))
			0: text.push_back(8'($urandom_range(8'h80, 8'hBF)));
			1: text.push_back(8'($urandom_range(8'hC0, 8'hC1)));
			2: text.push_back(8'($urandom_range(8'hF0, 8'hFF)));
			3: begin
				// cut a sequence short with a byte that is not a continuation
				if ($urandom_range(0, 1)) begin
					text.push_back(8'($urandom_range(8'hC2, 8'hDF)));
				end else begin
					text.push_back(8'($urandom_range(8'hE0, 8'hEF)));
					if ($urandom_range(0, 1))
						text.push_back(8'($urandom_range(8'h80, 8'hBF)));
				end
				do stop = 8'($urandom); while (stop[7:6] == 2'b10);
				text.push_back(stop);
			end
			4: begin
				text.push_back(8'hE0);
				text.push_back(8'($urandom_range(8'h80, 8'h9F)));
				text.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end
			default: begin
				text.push_back(8'hED);
				text.push_back(8'($urandom_range(8'hA0, 8'hBF)));
				text.push_back(8'($urandom_range(8'h80, 8'hBF)));
			end
			endcase
			repeat ($urandom_range(0, 4)) text.push_back(8'($urandom_range(1, 255)));
		end else if (shape == 9) begin
			repeat ($urandom_range(1, 6)) text.push_back(8'($urandom));
		end
		text.push_back(8'h00);
	endfunction

	// Stimulus and verdict
	initial begin
		logic [15:0] caps [PHASES];
		arst_n <= 1'b0;
		caps = '{CAP_RESET, 16'd1, 16'd2, 16'd3, 16'($urandom_range(4, 10)), CAP_RESET};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_capacity(CAP_RESET);
		text = directed_text;
		send_text();

		for (int p = 0; p < PHASES; p++) begin
			set_capacity(caps[p]);
			// calm stretches in the middle and at the end
			idle_on       = (p != 2 && p != PHASES - 1);
			sent_in_phase = 0;
			while (sent_in_phase < PHASE_BYTES) begin
				if (p == 0 && sent_in_phase >= 40)
					long_hold_req = 1'b1;
				build_text();
				send_text();
			end
		end

		drain();
		if (fail_count == 0 && words_pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
